@@ sv/bsz_pkg.sv @@
package bsz_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SUM_W      = 12;
  localparam int FWIDTH_W   = 6;
  localparam int FHEIGHT_W  = 11;
  localparam int ROW_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 6'd10;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd10;
  localparam logic [FHEIGHT_W-1:0] HEIGHT_LIMIT     = 11'd1024;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_SETTLE,
    ST_MID,
    ST_EDGE,
    ST_FSETTLE,
    ST_FLUSH
  } state_e;

  // controls shared by every cell of the row
  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_slot;
    logic [1:0] slot0;
    logic [1:0] slot1;
    logic [1:0] slot2;
    logic       en1;
    logic       en2;
  } cell_ctrl_t;

endpackage

@@ sv/box_sum_3x3_zero_pad.sv @@
// 3x3 box sum with zero padding over a raster-order pixel stream. A row of
// MAX_WIDTH column cells keeps the last three rows; each cell registers its
// column sum every cycle and adds its two neighbors' sums to form its box.
// A pixel with no result leaves the block ready. For a pixel with results,
// the cells' column sums settle after it is accepted, then one result goes
// out per cycle while the output is taken (up to 2 results at a row end).
// The last pixel of a frame adds one more settle step, then one result per
// column at that rate. A finished result waits in the output register
// while the next pixel is accepted. Width and height may be written between
// pixels; positions past a new last column or row saturate to it.
module box_sum_3x3_zero_pad #(
  parameter int MAX_WIDTH  = 32,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsz_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              pixel_valid_i,
  output logic                              pixel_ready_o,
  input  logic [bsz_pkg::PIXEL_W-1:0]       pixel_value_i,
  output logic                              box_valid_o,
  input  logic                              box_ready_i,
  output logic [bsz_pkg::SUM_W-1:0]         box_sum_o,
  output logic                              last_of_run_o,
  output logic                              frame_end_o
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int VW   = PIXEL_BITS + 2;
  localparam int SW   = PIXEL_BITS + 4;
  localparam int KEEP = (PIXEL_BITS < bsz_pkg::PIXEL_W) ? PIXEL_BITS : bsz_pkg::PIXEL_W;

  logic [bsz_pkg::FWIDTH_W-1:0]  frame_width_q;
  logic [bsz_pkg::FHEIGHT_W-1:0] frame_height_q;

  logic [CW-1:0]                 col_q, col_d;
  logic [bsz_pkg::ROW_W-1:0]     row_q, row_d;
  logic [1:0]                    sel_q, sel_d;

  logic [1:0]                    job_sel_q;
  logic                          job_r1_q, job_r2_q;
  logic [CW-1:0]                 job_col_q;
  logic                          job_mid_q, job_edge_q, job_flush_q;
  logic [CW-1:0]                 flush_col_q, flush_col_d;

  bsz_pkg::state_e               state_q, state_d;

  logic                          box_valid_q, box_valid_d;
  logic [bsz_pkg::SUM_W-1:0]     box_sum_q;
  logic                          last_q, frame_end_q;

  logic [CW-1:0]                 wlast_w;
  logic [bsz_pkg::ROW_W-1:0]     hlast_w;
  logic [CW-1:0]                 col_sat;
  logic [bsz_pkg::ROW_W-1:0]     row_sat;
  logic                          row_end, frame_done, has_mid, has_edge;
  logic                          in_fire;
  logic                          flush_mode;
  logic [PIXEL_BITS-1:0]         pix_w;
  bsz_pkg::cell_ctrl_t           cell_ctrl;

  logic                          emit_go;
  logic [CW-1:0]                 rd_col;
  logic                          emit_last, emit_fend;

  logic [VW-1:0]                 v_w     [MAX_WIDTH];
  logic [VW-1:0]                 v_left  [MAX_WIDTH];
  logic [VW-1:0]                 v_right [MAX_WIDTH];
  logic [SW-1:0]                 box_w   [MAX_WIDTH];

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bsz_pkg::FRAME_WIDTH_RST;
      frame_height_q <= bsz_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsz_pkg::CFG_FRAME_WIDTH:
          frame_width_q <= cfg_wdata_i[bsz_pkg::FWIDTH_W-1:0];
        bsz_pkg::CFG_FRAME_HEIGHT:
          frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      wlast_w = '0;
    end else if (frame_width_q > bsz_pkg::FWIDTH_W'(MAX_WIDTH)) begin
      wlast_w = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_w = CW'(frame_width_q - 6'd1);
    end
  end

  always_comb begin
    if (frame_height_q == '0) begin
      hlast_w = '0;
    end else if (frame_height_q > bsz_pkg::HEIGHT_LIMIT) begin
      hlast_w = bsz_pkg::ROW_W'(bsz_pkg::HEIGHT_LIMIT - 11'd1);
    end else begin
      hlast_w = bsz_pkg::ROW_W'(frame_height_q - 11'd1);
    end
  end

  // ---------------- position tracking ----------------
  assign pixel_ready_o = (state_q == bsz_pkg::ST_RUN);
  assign in_fire       = pixel_valid_i && pixel_ready_o;

  assign col_sat    = (col_q > wlast_w) ? wlast_w : col_q;
  assign row_sat    = (row_q > hlast_w) ? hlast_w : row_q;
  assign row_end    = (col_sat == wlast_w);
  assign frame_done = row_end && (row_sat == hlast_w);
  assign has_mid    = (row_sat != '0) && (col_sat != '0);
  assign has_edge   = (row_sat != '0) && row_end;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    sel_d = sel_q;
    if (in_fire) begin
      if (row_end) begin
        col_d = '0;
        if (frame_done) begin
          row_d = '0;
          sel_d = '0;
        end else begin
          row_d = row_sat + 10'd1;
          sel_d = (sel_q == 2'd2) ? 2'd0 : sel_q + 2'd1;
        end
      end else begin
        col_d = col_sat + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sel_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      sel_q <= sel_d;
    end
  end

  // what the accepted pixel still owes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_mid_q   <= 1'b0;
      job_edge_q  <= 1'b0;
      job_flush_q <= 1'b0;
    end else if (in_fire) begin
      job_mid_q   <= has_mid;
      job_edge_q  <= has_edge;
      job_flush_q <= frame_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_sel_q <= sel_q;
      job_r1_q  <= (row_sat != '0);
      job_r2_q  <= (row_sat > 10'd1);
      job_col_q <= col_sat;
    end
  end

  // ---------------- cell row ----------------
  assign pix_w      = PIXEL_BITS'(pixel_value_i[KEEP-1:0]);
  assign flush_mode = (state_q == bsz_pkg::ST_FSETTLE) || (state_q == bsz_pkg::ST_FLUSH);

  always_comb begin
    cell_ctrl.wr_en   = in_fire;
    cell_ctrl.wr_slot = sel_q;
    cell_ctrl.slot0   = job_sel_q;
    cell_ctrl.slot1   = (job_sel_q == 2'd0) ? 2'd2 : job_sel_q - 2'd1;
    cell_ctrl.slot2   = (job_sel_q == 2'd0) ? 2'd1 :
                        (job_sel_q == 2'd1) ? 2'd2 : 2'd0;
    // flush centres sit on the last row: no row below, row above if any
    cell_ctrl.en1     = flush_mode ? job_r1_q : 1'b1;
    cell_ctrl.en2     = flush_mode ? 1'b0 : job_r2_q;
  end

  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
    if (j == 0) begin : g_lft
      assign v_left[j] = '0;
    end else begin : g_lft
      assign v_left[j] = v_w[j-1];
    end
    if (j == MAX_WIDTH - 1) begin : g_rgt
      assign v_right[j] = '0;
    end else begin : g_rgt
      assign v_right[j] = v_w[j+1];
    end

    bsz_cell #(
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_WIDTH  (MAX_WIDTH),
      .INDEX      (j)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .wr_col_i  (col_sat),
      .wlast_i   (wlast_w),
      .pixel_i   (pix_w),
      .v_left_i  (v_left[j]),
      .v_right_i (v_right[j]),
      .v_o       (v_w[j]),
      .box_o     (box_w[j])
    );
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsz_pkg::ST_RUN: begin
        if (in_fire) begin
          if (has_mid || has_edge) begin
            state_d = bsz_pkg::ST_SETTLE;
          end else if (frame_done) begin
            state_d = bsz_pkg::ST_FSETTLE;
          end
        end
      end
      bsz_pkg::ST_SETTLE: begin
        state_d = job_mid_q ? bsz_pkg::ST_MID : bsz_pkg::ST_EDGE;
      end
      bsz_pkg::ST_MID: begin
        if (emit_go) begin
          state_d = job_edge_q  ? bsz_pkg::ST_EDGE :
                    job_flush_q ? bsz_pkg::ST_FSETTLE : bsz_pkg::ST_RUN;
        end
      end
      bsz_pkg::ST_EDGE: begin
        if (emit_go) begin
          state_d = job_flush_q ? bsz_pkg::ST_FSETTLE : bsz_pkg::ST_RUN;
        end
      end
      bsz_pkg::ST_FSETTLE: begin
        state_d = bsz_pkg::ST_FLUSH;
      end
      bsz_pkg::ST_FLUSH: begin
        if (emit_go && (flush_col_q == wlast_w)) begin
          state_d = bsz_pkg::ST_RUN;
        end
      end
      default: state_d = bsz_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    emit_go   = 1'b0;
    rd_col    = '0;
    emit_last = 1'b0;
    emit_fend = 1'b0;
    unique case (state_q)
      bsz_pkg::ST_MID: begin
        emit_go   = !box_valid_q || box_ready_i;
        rd_col    = job_col_q - CW'(1);
        emit_last = !(job_edge_q || job_flush_q);
      end
      bsz_pkg::ST_EDGE: begin
        emit_go   = !box_valid_q || box_ready_i;
        rd_col    = wlast_w;
        emit_last = !job_flush_q;
      end
      bsz_pkg::ST_FLUSH: begin
        emit_go   = !box_valid_q || box_ready_i;
        rd_col    = flush_col_q;
        emit_last = (flush_col_q == wlast_w);
        emit_fend = (flush_col_q == wlast_w);
      end
      default: ;
    endcase
  end

  always_comb begin
    flush_col_d = flush_col_q;
    if (state_q == bsz_pkg::ST_FSETTLE) begin
      flush_col_d = '0;
    end else if ((state_q == bsz_pkg::ST_FLUSH) && emit_go && (flush_col_q != wlast_w)) begin
      flush_col_d = flush_col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsz_pkg::ST_RUN;
      flush_col_q <= '0;
    end else begin
      state_q     <= state_d;
      flush_col_q <= flush_col_d;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    box_valid_d = box_valid_q;
    if (emit_go) begin
      box_valid_d = 1'b1;
    end else if (box_ready_i) begin
      box_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
    end else begin
      box_valid_q <= box_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      box_sum_q   <= bsz_pkg::SUM_W'(box_w[rd_col]);
      last_q      <= emit_last;
      frame_end_q <= emit_fend;
    end
  end

  assign box_valid_o   = box_valid_q;
  assign box_sum_o     = box_sum_q;
  assign last_of_run_o = last_q;
  assign frame_end_o   = frame_end_q;

  // ---------------- checks ----------------
  a_frame_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_o && frame_end_o |-> last_of_run_o)
    else $error("frame_end without last_of_run");

  a_flush_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsz_pkg::ST_FLUSH |-> flush_col_q <= wlast_w)
    else $error("flush column past last column");

  a_mid_not_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsz_pkg::ST_MID |-> job_col_q != '0)
    else $error("mid-row result for first column");

  a_transfer_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (has_mid || has_edge || frame_done) |=> state_q != bsz_pkg::ST_RUN)
    else $error("pixel with pending results did not start the sequencer");

endmodule

@@ sv/bsz_cell.sv @@
module bsz_cell #(
  parameter int PIXEL_BITS = 8,
  parameter int MAX_WIDTH  = 32,
  parameter int INDEX      = 0
) (
  input  logic                          clk_i,
  input  bsz_pkg::cell_ctrl_t           ctrl_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_col_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wlast_i,
  input  logic [PIXEL_BITS-1:0]         pixel_i,
  input  logic [PIXEL_BITS+1:0]         v_left_i,
  input  logic [PIXEL_BITS+1:0]         v_right_i,
  output logic [PIXEL_BITS+1:0]         v_o,
  output logic [PIXEL_BITS+3:0]         box_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int VW = PIXEL_BITS + 2;
  localparam int SW = PIXEL_BITS + 4;

  logic [PIXEL_BITS-1:0] pix0_q, pix1_q, pix2_q;
  logic [VW-1:0]         v_q, v_d;
  logic                  hit;
  logic                  in_frame;

  function automatic logic [PIXEL_BITS-1:0] pick(
    input logic [1:0]            s,
    input logic [PIXEL_BITS-1:0] a,
    input logic [PIXEL_BITS-1:0] b,
    input logic [PIXEL_BITS-1:0] c
  );
    logic [PIXEL_BITS-1:0] r;
    case (s)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  assign hit      = ctrl_i.wr_en && (wr_col_i == CW'(INDEX));
  assign in_frame = (CW'(INDEX) <= wlast_i);

  // one pixel per row slot for this column
  always_ff @(posedge clk_i) begin
    if (hit) begin
      case (ctrl_i.wr_slot)
        2'd0:    pix0_q <= pixel_i;
        2'd1:    pix1_q <= pixel_i;
        default: pix2_q <= pixel_i;
      endcase
    end
  end

  // column sum, zero outside the frame or above the first row
  always_comb begin
    v_d = '0;
    if (in_frame) begin
      v_d = VW'(pick(ctrl_i.slot0, pix0_q, pix1_q, pix2_q));
      if (ctrl_i.en1) begin
        v_d = v_d + VW'(pick(ctrl_i.slot1, pix0_q, pix1_q, pix2_q));
      end
      if (ctrl_i.en2) begin
        v_d = v_d + VW'(pick(ctrl_i.slot2, pix0_q, pix1_q, pix2_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o   = v_q;
  assign box_o = SW'(v_left_i) + SW'(v_q) + SW'(v_right_i);

endmodule

@@ bench/box_sum_checker.sv @@
`timescale 1ns / 100ps

module box_sum_checker #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsz_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           pixel_valid_i,
  input  logic                           pixel_ready_i,
  input  logic [bsz_pkg::PIXEL_W-1:0]    pixel_value_i,
  input  logic                           box_valid_i,
  input  logic                           box_ready_i,
  input  logic [bsz_pkg::SUM_W-1:0]      box_sum_i,
  input  logic                           last_of_run_i,
  input  logic                           frame_end_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);

  typedef struct packed {
    logic [bsz_pkg::SUM_W-1:0] sum;
    logic                      last_of_run;
    logic                      frame_end;
  } box_result_t;

  // three most recent rows, indexed by slot
  logic [bsz_pkg::PIXEL_W-1:0]   line_buf [3][MAX_WIDTH];
  logic [4:0]                    col_q;
  logic [bsz_pkg::ROW_W-1:0]     row_q;
  logic [1:0]                    slot_q;
  logic [bsz_pkg::FWIDTH_W-1:0]  width_q;
  logic [bsz_pkg::FHEIGHT_W-1:0] height_q;

  box_result_t expected_sums_q[$];
  int          errors = 0;
  int          results_seen = 0;

  assign fail_count_o = errors;

  function automatic int active_width();
    if (width_q == '0) return 1;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic int active_height();
    if (height_q == '0) return 1;
    if (height_q > bsz_pkg::HEIGHT_LIMIT) return int'(bsz_pkg::HEIGHT_LIMIT);
    return int'(height_q);
  endfunction

  // pixel `back` rows above the current one; zero outside the image
  function automatic logic [bsz_pkg::PIXEL_W-1:0] tap(int back, int x, int w);
    if (back < 0 || back > 2 || int'(row_q) - back < 0 || x < 0 || x >= w) return '0;
    return line_buf[(int'(slot_q) + 3 - back) % 3][x];
  endfunction

  function automatic logic [bsz_pkg::SUM_W-1:0] window_sum(int back, int x, int w);
    logic [bsz_pkg::SUM_W-1:0] acc;
    acc = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        acc = acc + bsz_pkg::SUM_W'(tap(back + dr, x + dc, w));
      end
    end
    return acc;
  endfunction

  task automatic predict_pixel(input logic [bsz_pkg::PIXEL_W-1:0] value);
    int                        w;
    int                        h;
    int                        c;
    int                        r;
    logic                      row_end;
    logic                      done;
    logic [bsz_pkg::SUM_W-1:0] sums[$];
    box_result_t               item;
    w = active_width();
    h = active_height();
    // a shrink between pixels pulls the position back onto the image
    if (int'(col_q) > w - 1) col_q = 5'(w - 1);
    if (int'(row_q) > h - 1) row_q = bsz_pkg::ROW_W'(h - 1);
    c = int'(col_q);
    r = int'(row_q);
    row_end = (c == w - 1);
    done = row_end && (r == h - 1);
    line_buf[slot_q][c] = value;
    if (r >= 1) begin
      if (c >= 1) sums.push_back(window_sum(1, c - 1, w));
      if (row_end) sums.push_back(window_sum(1, w - 1, w));
    end
    if (done) begin
      for (int k = 0; k < w; k++) sums.push_back(window_sum(0, k, w));
    end
    foreach (sums[i]) begin
      item.sum = sums[i];
      item.last_of_run = (i == sums.size() - 1);
      item.frame_end = done && (i == sums.size() - 1);
      expected_sums_q.push_back(item);
    end
    if (row_end) begin
      col_q = '0;
      if (done) begin
        row_q = '0;
        slot_q = '0;
      end else begin
        row_q = row_q + 1'b1;
        slot_q = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
      end
    end else begin
      col_q = col_q + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("box_sum_checker: %s", msg);
  endtask

  task automatic check_result();
    box_result_t want;
    results_seen++;
    if (expected_sums_q.size() == 0) begin
      report_mismatch($sformatf("result %0d (sum %0d) with nothing pending",
                                results_seen, box_sum_i));
    end else begin
      want = expected_sums_q.pop_front();
      if (box_sum_i !== want.sum)
        report_mismatch($sformatf("result %0d box_sum got %0d expected %0d",
                                  results_seen, box_sum_i, want.sum));
      if (last_of_run_i !== want.last_of_run)
        report_mismatch($sformatf("result %0d last_of_run got %0b expected %0b",
                                  results_seen, last_of_run_i, want.last_of_run));
      if (frame_end_i !== want.frame_end)
        report_mismatch($sformatf("result %0d frame_end got %0b expected %0b",
                                  results_seen, frame_end_i, want.frame_end));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q = '0;
      row_q = '0;
      slot_q = '0;
      width_q = bsz_pkg::FRAME_WIDTH_RST;
      height_q = bsz_pkg::FRAME_HEIGHT_RST;
      expected_sums_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bsz_pkg::CFG_FRAME_WIDTH: width_q = cfg_wdata_i[bsz_pkg::FWIDTH_W-1:0];
          bsz_pkg::CFG_FRAME_HEIGHT: height_q = cfg_wdata_i[bsz_pkg::FHEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (box_valid_i && box_ready_i) check_result();
      if (pixel_valid_i && pixel_ready_i) predict_pixel(pixel_value_i);
      outstanding_o <= expected_sums_q.size();
    end
  end

endmodule

@@ bench/box_sum_3x3_zero_pad_test.sv @@
`timescale 1ns / 100ps

module box_sum_3x3_zero_pad_test;

  localparam int RANDOM_ITEMS  = 340;
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bsz_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [bsz_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           pixel_valid_i;
  logic                           pixel_ready_o;
  logic [bsz_pkg::PIXEL_W-1:0]    pixel_value_i;
  logic                           box_valid_o;
  logic                           box_ready_i = 1'b0;
  logic [bsz_pkg::SUM_W-1:0]      box_sum_o;
  logic                           last_of_run_o;
  logic                           frame_end_o;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int stall_left = 0;
  int calm_left = 0;

  // sender's view of the raster position and the register values
  int                            col_at;
  int                            row_at;
  logic [bsz_pkg::FWIDTH_W-1:0]  raw_w;
  logic [bsz_pkg::FHEIGHT_W-1:0] raw_h;
  int                            random_sent;

  box_sum_3x3_zero_pad u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_value_i (pixel_value_i),
    .box_valid_o   (box_valid_o),
    .box_ready_i   (box_ready_i),
    .box_sum_o     (box_sum_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o)
  );

  box_sum_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_i (pixel_ready_o),
    .pixel_value_i (pixel_value_i),
    .box_valid_i   (box_valid_o),
    .box_ready_i   (box_ready_i),
    .box_sum_i     (box_sum_o),
    .last_of_run_i (last_of_run_o),
    .frame_end_i   (frame_end_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_sum_3x3_zero_pad_test: FAIL");
      $finish;
    end
  end

  // result side backpressure: calm stretches, short stalls, rare long ones
  always @(posedge clk_i) begin : sink_pacing
    int roll;
    if (!rst_ni) begin
      box_ready_i <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      box_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      box_ready_i <= 1'b0;
    end else begin
      box_ready_i <= 1'b1;
      roll = $urandom_range(0, 39);
      if (roll == 0) calm_left <= $urandom_range(50, 300);
      else if (roll >= 20 && roll < 37) stall_left <= $urandom_range(1, 3);
      else if (roll >= 37) stall_left <= $urandom_range(8, 24);
    end
  end

  function automatic int frame_cols(input logic [bsz_pkg::FWIDTH_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > 32) return 32;
    return int'(raw);
  endfunction

  function automatic int frame_rows(input logic [bsz_pkg::FHEIGHT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > bsz_pkg::HEIGHT_LIMIT) return int'(bsz_pkg::HEIGHT_LIMIT);
    return int'(raw);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [bsz_pkg::PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return bsz_pkg::PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [bsz_pkg::CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 11'd32;
      1: return bsz_pkg::CFG_DATA_W'($urandom_range(33, 63));
      2: return 11'd0;
      3: return bsz_pkg::CFG_DATA_W'($urandom_range(9, 31));
      default: return bsz_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [bsz_pkg::CFG_DATA_W-1:0] pick_height(input int cols);
    if (cols > 8) return bsz_pkg::CFG_DATA_W'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return bsz_pkg::CFG_DATA_W'($urandom_range(7, 40));
      default: return bsz_pkg::CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  // hold off until every pending result has been taken, then let the block go quiet
  task automatic settle();
    pixel_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [bsz_pkg::CFG_DATA_W-1:0] w,
                           input logic [bsz_pkg::CFG_DATA_W-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_index_i <= bsz_pkg::CFG_FRAME_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_index_i <= bsz_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    raw_w = w[bsz_pkg::FWIDTH_W-1:0];
    raw_h = h[bsz_pkg::FHEIGHT_W-1:0];
  endtask

  task automatic send_pixel(input logic [bsz_pkg::PIXEL_W-1:0] value, input bit steady);
    int gap;
    int w;
    int h;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_value_i <= value;
    do @(posedge clk_i); while (!pixel_ready_o);
    // track the raster position to know where frames end
    w = frame_cols(raw_w);
    h = frame_rows(raw_h);
    if (col_at > w - 1) col_at = w - 1;
    if (row_at > h - 1) row_at = h - 1;
    if (col_at == w - 1) begin
      col_at = 0;
      row_at = (row_at == h - 1) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
  endtask

  initial begin
    logic [bsz_pkg::CFG_DATA_W-1:0] new_w;
    logic [bsz_pkg::CFG_DATA_W-1:0] new_h;
    bit                             steady;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = bsz_pkg::CFG_FRAME_WIDTH;
    cfg_wdata_i = '0;
    pixel_valid_i = 1'b0;
    pixel_value_i = '0;
    col_at = 0;
    row_at = 0;
    raw_w = bsz_pkg::FRAME_WIDTH_RST;
    raw_h = bsz_pkg::FRAME_HEIGHT_RST;
    random_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-max 3x3 frame: centre hits the largest sum
    write_cfg(11'd3, 11'd3);
    repeat (9) send_pixel(8'hFF, 1'b0);
    // single pixel frames, including zero width and height acting as one
    settle();
    write_cfg(11'd1, 11'd1);
    send_pixel(8'hFF, 1'b0);
    settle();
    write_cfg(11'd0, 11'd0);
    send_pixel(8'h00, 1'b0);
    settle();
    write_cfg(11'd2, 11'd2);
    send_pixel(8'd1, 1'b1);
    send_pixel(8'd2, 1'b1);
    send_pixel(8'd4, 1'b1);
    send_pixel(8'd128, 1'b1);
    // a single row is both first and last row
    settle();
    write_cfg(11'd4, 11'd1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    // narrow the frame mid-row so the column saturates and the frame closes
    settle();
    write_cfg(11'd3, 11'd3);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b0);
    send_pixel(8'd40, 1'b0);
    settle();
    write_cfg(11'd1, 11'd2);
    send_pixel(8'd50, 1'b0);

    // widest frames, then out of range height cut short below the current row
    settle();
    write_cfg(11'd32, 11'd2);
    repeat (64) send_pixel(pick_pixel(), 1'b0);
    settle();
    write_cfg(11'd63, 11'd1);
    repeat (32) send_pixel(pick_pixel(), 1'b0);
    settle();
    write_cfg(11'd0, 11'd2047);
    repeat (20) send_pixel(pick_pixel(), 1'($urandom_range(0, 1)));
    settle();
    write_cfg(11'd0, 11'd3);
    send_pixel(pick_pixel(), 1'b0);

    while (random_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        new_w = pick_width();
        new_h = pick_height(frame_cols(new_w[bsz_pkg::FWIDTH_W-1:0]));
        settle();
        write_cfg(new_w, new_h);
      end
      do begin
        // mid-frame change: width may only shrink, rows above stay valid
        if ((col_at != 0 || row_at != 0) && $urandom_range(0, 59) == 0) begin
          settle();
          new_w = bsz_pkg::CFG_DATA_W'($urandom_range(0, frame_cols(raw_w)));
          new_h = bsz_pkg::CFG_DATA_W'($urandom_range(0, 12));
          write_cfg(new_w, new_h);
        end
        send_pixel(pick_pixel(), steady);
        random_sent++;
      end while (col_at != 0 || row_at != 0);
    end

    pixel_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("box_sum_3x3_zero_pad_test: PASS");
    end else begin
      $display("box_sum_3x3_zero_pad_test: FAIL");
    end
    $finish;
  end

endmodule
